### hdl/stepper_ramp_pulse_generator_unit_defines.svh
// Assertion macros shared by the stepper ramp pulse generator RTL.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_UNIT_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define SRPG_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define SRPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/srpg_pkg.sv
// Shared constants, types and helper functions of the stepper ramp pulse generator.
package srpg_pkg;

  localparam int STEP_COUNT_BITS = 20;
  localparam int DELAY_BITS      = 16;

  localparam int MOVE_BITS   = 16;
  localparam int CFG_DW_BITS = 16;  // delay-class register width
  localparam int SPC_BITS    = 4;
  localparam int UFACT_BITS  = 5;

  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;

  localparam int PROD_BITS      = MOVE_BITS + UFACT_BITS;
  localparam int STEP_WIDE_BITS = (PROD_BITS > STEP_COUNT_BITS) ? PROD_BITS : STEP_COUNT_BITS;
  localparam int DELAY_WIDE_BITS =
    ((DELAY_BITS > CFG_DW_BITS) ? DELAY_BITS : CFG_DW_BITS) + 1;

  localparam logic [STEP_COUNT_BITS-1:0] STEP_MAX   = {STEP_COUNT_BITS{1'b1}};
  localparam logic [DELAY_BITS-1:0]      DELAY_CEIL = {DELAY_BITS{1'b1}};

  // Register reset values
  localparam logic [CFG_DW_BITS-1:0] MIN_DELAY_RST  = CFG_DW_BITS'(1000);
  localparam logic [CFG_DW_BITS-1:0] MAX_DELAY_RST  = CFG_DW_BITS'(3000);
  localparam logic [CFG_DW_BITS-1:0] DELAY_STEP_RST = CFG_DW_BITS'(100);
  localparam logic [SPC_BITS-1:0]    SPC_RST        = SPC_BITS'(5);
  localparam logic [CFG_DW_BITS-1:0] RAMP_LEN_RST   = CFG_DW_BITS'(100);
  localparam logic [UFACT_BITS-1:0]  UFACT_RST      = UFACT_BITS'(8);

  // Input op codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_MIN_DELAY        = 3'd0,
    REG_MAX_DELAY        = 3'd1,
    REG_DELAY_STEP       = 3'd2,
    REG_STEPS_PER_CHANGE = 3'd3,
    REG_RAMP_LENGTH      = 3'd4,
    REG_MICROSTEP_FACTOR = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_DW_BITS-1:0] min_delay;
    logic [CFG_DW_BITS-1:0] max_delay;
    logic [CFG_DW_BITS-1:0] delay_step;
    logic [SPC_BITS-1:0]    steps_per_change;
    logic [CFG_DW_BITS-1:0] ramp_length;
    logic [UFACT_BITS-1:0]  microstep_factor;
  } cfg_t;

  // Clamp a register value into the delay range.
  function automatic logic [DELAY_BITS-1:0] sat_delay(input logic [CFG_DW_BITS-1:0] v);
    logic [DELAY_WIDE_BITS-1:0] v_w;
    v_w = DELAY_WIDE_BITS'(v);
    if (v_w > DELAY_WIDE_BITS'(DELAY_CEIL)) begin
      return DELAY_CEIL;
    end
    return DELAY_BITS'(v_w);
  endfunction

  // A zero delay still lasts one tick.
  function automatic logic [DELAY_BITS-1:0] half_period(input logic [DELAY_BITS-1:0] d);
    if (d == '0) begin
      return DELAY_BITS'(1);
    end
    return d;
  endfunction

endpackage

### hdl/srpg_in_if.sv
// Input channel: tick or start-move transactions.
interface srpg_in_if import srpg_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic [MOVE_BITS-1:0] move_steps;

  modport source (output valid, output op, output move_steps, input ready);
  modport sink   (input valid, input op, input move_steps, output ready);
endinterface

### hdl/srpg_out_if.sv
// Result channel: step level, busy and move-done flags.
interface srpg_out_if import srpg_pkg::*; ();
  logic valid;
  logic ready;
  logic step_level;
  logic busy_res;
  logic move_done;

  modport source (output valid, output step_level, output busy_res, output move_done,
                  input ready);
  modport sink   (input valid, input step_level, input busy_res, input move_done,
                  output ready);
endinterface

### hdl/srpg_cfg_regs.sv
// APB-style configuration register file of the ramp generator.
module srpg_cfg_regs import srpg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output cfg_t                     cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  cfg_reg_t reg_idx;

  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = cfg_reg_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign cfg     = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_delay        <= MIN_DELAY_RST;
      cfg_r.max_delay        <= MAX_DELAY_RST;
      cfg_r.delay_step       <= DELAY_STEP_RST;
      cfg_r.steps_per_change <= SPC_RST;
      cfg_r.ramp_length      <= RAMP_LEN_RST;
      cfg_r.microstep_factor <= UFACT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN_DELAY:        cfg_r.min_delay        <= pwdata[CFG_DW_BITS-1:0];
        REG_MAX_DELAY:        cfg_r.max_delay        <= pwdata[CFG_DW_BITS-1:0];
        REG_DELAY_STEP:       cfg_r.delay_step       <= pwdata[CFG_DW_BITS-1:0];
        REG_STEPS_PER_CHANGE: cfg_r.steps_per_change <= pwdata[SPC_BITS-1:0];
        REG_RAMP_LENGTH:      cfg_r.ramp_length      <= pwdata[CFG_DW_BITS-1:0];
        REG_MICROSTEP_FACTOR: cfg_r.microstep_factor <= pwdata[UFACT_BITS-1:0];
        default: ;  // unmapped addresses ignore writes
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_DELAY:        prdata = CFG_DATA_BITS'(cfg_r.min_delay);
      REG_MAX_DELAY:        prdata = CFG_DATA_BITS'(cfg_r.max_delay);
      REG_DELAY_STEP:       prdata = CFG_DATA_BITS'(cfg_r.delay_step);
      REG_STEPS_PER_CHANGE: prdata = CFG_DATA_BITS'(cfg_r.steps_per_change);
      REG_RAMP_LENGTH:      prdata = CFG_DATA_BITS'(cfg_r.ramp_length);
      REG_MICROSTEP_FACTOR: prdata = CFG_DATA_BITS'(cfg_r.microstep_factor);
      default:              prdata = '0;
    endcase
  end

endmodule

### hdl/stepper_ramp_pulse_generator_unit.sv
// Top level: trapezoidal stepper ramp pulse generator with input and result registers.
//
//  channel  | dir | transaction                          | handshake
//  ---------+-----+--------------------------------------+----------------------
//  in_chan  | in  | op (tick / start), move_steps        | valid/ready
//  out_chan | out | step_level, busy_res, move_done      | valid/ready
//  cfg_*    | in  | 6 registers at byte address 4*index  | APB write, pready = 1
//
// One transaction per clock sustained while out_chan.ready stays high; each passes
// through the input register, then the step/ramp logic feeding the result register.
// Throughput is set by the state update in the step/ramp logic.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// A stalled result holds the output register; one more input transaction can wait
// in the input register, after which in_chan.ready drops.
module stepper_ramp_pulse_generator_unit import srpg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  srpg_in_if.sink                  in_chan,
  srpg_out_if.source               out_chan,
  input  logic                     cfg_psel,
  input  logic                     cfg_penable,
  input  logic                     cfg_pwrite,
  input  logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0] cfg_prdata,
  output logic                     cfg_pready
);

`include "stepper_ramp_pulse_generator_unit_defines.svh"

  cfg_t cfg;

  assign cfg_pready = 1'b1;

  srpg_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .pready  (cfg_pready),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                 s1_valid_r;
  logic                 s1_op_r;
  logic [MOVE_BITS-1:0] s1_steps_r;
  logic                 s1_adv;
  logic                 in_take;

  logic out_valid_r;
  logic out_level_r;
  logic out_busy_r;
  logic out_done_r;

  // The step logic fires when the input register holds a transaction and the
  // result register is free or being drained this cycle.
  assign s1_adv        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || s1_adv;
  assign in_take       = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r    <= in_chan.op;
      s1_steps_r <= in_chan.move_steps;
    end
  end

  // ---------------------------------------------------------------------------
  // Motion state
  // ---------------------------------------------------------------------------
  logic [STEP_COUNT_BITS-1:0] total_r, total_nxt;
  logic [STEP_COUNT_BITS-1:0] step_idx_r, step_idx_nxt;
  logic [STEP_COUNT_BITS-1:0] decel_pt_r, decel_pt_nxt;
  logic [DELAY_BITS-1:0]      cur_delay_r, cur_delay_nxt;
  logic [DELAY_BITS-1:0]      timer_r, timer_nxt;
  logic [SPC_BITS-1:0]        chg_cnt_r, chg_cnt_nxt;
  logic                       accel_r, accel_nxt;
  logic                       decel_r, decel_nxt;
  logic                       high_r, high_nxt;
  logic                       moving_r, moving_nxt;

  logic res_level;
  logic res_done;

  // Start path: move length in microsteps, saturated, and the decel point.
  logic [PROD_BITS-1:0]       prod;
  logic [STEP_WIDE_BITS-1:0]  prod_w;
  logic [STEP_COUNT_BITS-1:0] start_total;
  logic [STEP_COUNT_BITS-1:0] start_half;
  logic [STEP_COUNT_BITS-1:0] start_back;
  logic [STEP_COUNT_BITS-1:0] start_decel;

  assign prod        = PROD_BITS'(s1_steps_r) * PROD_BITS'(cfg.microstep_factor);
  assign prod_w      = STEP_WIDE_BITS'(prod);
  assign start_total = (prod_w > STEP_WIDE_BITS'(STEP_MAX)) ? STEP_MAX
                                                            : STEP_COUNT_BITS'(prod_w);
  assign start_half  = start_total >> 1;
  assign start_back  = (STEP_WIDE_BITS'(cfg.ramp_length) < STEP_WIDE_BITS'(start_half))
                       ? STEP_COUNT_BITS'(cfg.ramp_length) : start_half;
  assign start_decel = start_total - start_back;

  // Ramp arithmetic on the current delay, saturating both ways.
  logic [DELAY_WIDE_BITS-1:0] cur_w;
  logic [DELAY_WIDE_BITS-1:0] dstep_w;
  logic [DELAY_WIDE_BITS-1:0] sum_w;
  logic [DELAY_BITS-1:0]      delay_dec;
  logic [DELAY_BITS-1:0]      delay_inc;
  logic [DELAY_BITS-1:0]      min_sat;
  logic [DELAY_BITS-1:0]      max_sat;

  assign cur_w     = DELAY_WIDE_BITS'(cur_delay_r);
  assign dstep_w   = DELAY_WIDE_BITS'(cfg.delay_step);
  assign sum_w     = cur_w + dstep_w;
  assign delay_dec = (cur_w > dstep_w) ? DELAY_BITS'(cur_w - dstep_w) : '0;
  assign delay_inc = (sum_w > DELAY_WIDE_BITS'(DELAY_CEIL)) ? DELAY_CEIL
                                                            : DELAY_BITS'(sum_w);
  assign min_sat   = sat_delay(cfg.min_delay);
  assign max_sat   = sat_delay(cfg.max_delay);

  // Per-transaction state update. Blocking assignments follow the order of
  // events in one tick: step start, level sample, timer countdown, phase end.
  always_comb begin
    total_nxt     = total_r;
    step_idx_nxt  = step_idx_r;
    decel_pt_nxt  = decel_pt_r;
    cur_delay_nxt = cur_delay_r;
    timer_nxt     = timer_r;
    chg_cnt_nxt   = chg_cnt_r;
    accel_nxt     = accel_r;
    decel_nxt     = decel_r;
    high_nxt      = high_r;
    moving_nxt    = moving_r;
    res_level     = 1'b0;
    res_done      = 1'b0;

    if (s1_adv) begin
      if (s1_op_r == OP_START) begin
        // A start abandons any move in flight.
        total_nxt     = start_total;
        decel_pt_nxt  = start_decel;
        step_idx_nxt  = '0;
        cur_delay_nxt = max_sat;
        timer_nxt     = '0;
        chg_cnt_nxt   = '0;
        accel_nxt     = 1'b1;
        decel_nxt     = 1'b0;
        high_nxt      = 1'b0;
        moving_nxt    = (start_total != '0);
      end else if (moving_r) begin
        if (!high_r && (timer_r == '0)) begin
          // Step start: ramp counter, optional delay change, decel check.
          chg_cnt_nxt = chg_cnt_r + SPC_BITS'(1);
          if (chg_cnt_nxt == cfg.steps_per_change) begin
            chg_cnt_nxt = '0;
            if (accel_r) begin
              cur_delay_nxt = delay_dec;
              if (delay_dec <= min_sat) begin
                accel_nxt = 1'b0;
              end
            end else if (decel_r) begin
              cur_delay_nxt = delay_inc;
              if (delay_inc >= max_sat) begin
                decel_nxt = 1'b0;
              end
            end
          end
          if (step_idx_r == decel_pt_r) begin
            decel_nxt = 1'b1;
            accel_nxt = 1'b0;
          end
          high_nxt  = 1'b1;
          timer_nxt = half_period(cur_delay_nxt);
        end
        res_level = high_nxt;
        timer_nxt = timer_nxt - DELAY_BITS'(1);
        if (timer_nxt == '0) begin
          if (high_nxt) begin
            high_nxt  = 1'b0;
            timer_nxt = half_period(cur_delay_nxt);
          end else begin
            step_idx_nxt = step_idx_r + STEP_COUNT_BITS'(1);
            if (step_idx_nxt == total_r) begin
              moving_nxt = 1'b0;
              res_done   = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      step_idx_r  <= '0;
      decel_pt_r  <= '0;
      cur_delay_r <= sat_delay(MAX_DELAY_RST);
      timer_r     <= '0;
      chg_cnt_r   <= '0;
      accel_r     <= 1'b1;
      decel_r     <= 1'b0;
      high_r      <= 1'b0;
      moving_r    <= 1'b0;
    end else begin
      total_r     <= total_nxt;
      step_idx_r  <= step_idx_nxt;
      decel_pt_r  <= decel_pt_nxt;
      cur_delay_r <= cur_delay_nxt;
      timer_r     <= timer_nxt;
      chg_cnt_r   <= chg_cnt_nxt;
      accel_r     <= accel_nxt;
      decel_r     <= decel_nxt;
      high_r      <= high_nxt;
      moving_r    <= moving_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_level_r <= res_level;
      out_busy_r  <= moving_nxt;
      out_done_r  <= res_done;
    end
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.step_level = out_level_r;
  assign out_chan.busy_res   = out_busy_r;
  assign out_chan.move_done  = out_done_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `SRPG_ASSERT_NOW(a_ramp_dir_excl, 1'b1, !(accel_r && decel_r), "accel and decel both set")
  `SRPG_ASSERT_NOW(a_idx_in_move, moving_r, step_idx_r < total_r, "step index past move end")
  `SRPG_ASSERT_NEXT(a_done_stops, s1_adv && res_done, !moving_r, "move_done left block busy")
  `SRPG_ASSERT_NOW(a_full_stall, s1_valid_r && out_valid_r && !out_chan.ready,
                   !in_chan.ready, "input taken while both registers are held")

endmodule
